@@ rtl/core/tilw_pkg.sv @@
// Shared types and constants for the tensor-to-image layout writer.
// No dependencies; every other file of the block refers to it by scoped names.
package tilw_pkg;

	// Layout modes, as written to the mode register.
	typedef enum logic [1:0] {
		MODE_CHAN  = 2'd0,
		MODE_FOLD  = 2'd1,
		MODE_BATCH = 2'd2,
		MODE_SWAP  = 2'd3
	} layout_mode_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_N = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_H = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_W = 3'd4;

	// Field widths fixed by the interface.
	localparam int SIZE_W     = 13;
	localparam int VALUE_W    = 32;
	localparam int ADDR_OUT_W = 32;

	// Four lanes per pixel.
	localparam int LANE_W = 2;
	localparam logic [LANE_W-1:0] LAST_LANE = 2'd3;

	// Cycles for the derived strides to settle after a register write or reset.
	localparam int SETTLE_W = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

	// Default parameter values.
	localparam int DEF_MAX_DIM   = 4096;
	localparam int DEF_ADDR_BITS = 32;

	// Per-item control carried from the walker to the write stage.
	typedef struct packed {
		logic [LANE_W-1:0] lane;
		logic              pad;
		logic              done;
	} item_ctl_t;

endpackage

@@ rtl/core/tilw_cfg.sv @@
// Configuration registers and the strides derived from them.
// Depends on tilw_pkg.
module tilw_cfg #(
	parameter int MAX_DIM   = tilw_pkg::DEF_MAX_DIM,
	parameter int ADDR_BITS = tilw_pkg::DEF_ADDR_BITS,
	localparam int DIM_W    = $clog2(MAX_DIM + 1),
	localparam int PIX_W    = ADDR_BITS - 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tilw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tilw_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                restart,
	output logic                                busy,
	output tilw_pkg::layout_mode_t              mode,
	output logic [DIM_W-1:0]                    w_dim,
	output logic [DIM_W-1:0]                    h_dim,
	output logic [DIM_W-1:0]                    outer_lim,
	output logic [DIM_W-1:0]                    second_lim,
	output logic [PIX_W-1:0]                    row_step,
	output logic [PIX_W-1:0]                    plane_step,
	output logic [PIX_W-1:0]                    block_step
);

	tilw_pkg::layout_mode_t             mode_q;
	logic [tilw_pkg::SIZE_W-1:0]        size_n_q, size_c_q, size_h_q, size_w_q;
	logic [tilw_pkg::SETTLE_W-1:0]      settle_q;
	logic [DIM_W-1:0]                   n_q, c_q, h_q, w_q;
	logic [DIM_W-1:0]                   blk_dim;
	logic [DIM_W:0]                     blk_cnt, wblk_cnt;
	logic [PIX_W-1:0]                   width_q, plane_q;
	logic                               idx_ok;

	// Effective size: zero reads as one, anything above the maximum saturates.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [tilw_pkg::SIZE_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	// Decode the register index; writes beyond the list are dropped.
	always_comb begin
		unique case (cfg_index)
			tilw_pkg::REG_MODE, tilw_pkg::REG_SIZE_N, tilw_pkg::REG_SIZE_C,
			tilw_pkg::REG_SIZE_H, tilw_pkg::REG_SIZE_W: idx_ok = 1'b1;
			default: idx_ok = 1'b0;
		endcase
	end

	assign restart = cfg_write && idx_ok;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tilw_pkg::MODE_CHAN;
			size_n_q <= tilw_pkg::SIZE_W'(1);
			size_c_q <= tilw_pkg::SIZE_W'(1);
			size_h_q <= tilw_pkg::SIZE_W'(1);
			size_w_q <= tilw_pkg::SIZE_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				tilw_pkg::REG_MODE:   mode_q <= tilw_pkg::layout_mode_t'(cfg_data[1:0]);
				tilw_pkg::REG_SIZE_N: size_n_q <= cfg_data;
				tilw_pkg::REG_SIZE_C: size_c_q <= cfg_data;
				tilw_pkg::REG_SIZE_H: size_h_q <= cfg_data;
				tilw_pkg::REG_SIZE_W: size_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off items while the derived strides settle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= tilw_pkg::SETTLE_CYCLES;
		end else if (restart) begin
			settle_q <= tilw_pkg::SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - tilw_pkg::SETTLE_W'(1);
		end
	end

	assign busy = (settle_q != '0);

	// The blocked dimension is channels in channel mode, batch otherwise.
	assign blk_dim  = (mode_q == tilw_pkg::MODE_CHAN) ? c_q : n_q;
	assign blk_cnt  = ({1'b0, blk_dim} + (DIM_W+1)'(3)) >> 2;
	assign wblk_cnt = ({1'b0, w_q} + (DIM_W+1)'(3)) >> 2;

	// Stride pipeline: sizes, then row width, then plane size.
	always_ff @(posedge clk) begin
		n_q     <= eff_dim(size_n_q);
		c_q     <= eff_dim(size_c_q);
		h_q     <= eff_dim(size_h_q);
		w_q     <= eff_dim(size_w_q);
		width_q <= PIX_W'(w_q) * PIX_W'(blk_cnt);
		plane_q <= PIX_W'(h_q * width_q);
	end

	// Loop limits per mode.
	always_comb begin
		unique case (mode_q)
			tilw_pkg::MODE_CHAN, tilw_pkg::MODE_BATCH: begin
				outer_lim  = n_q;
				second_lim = c_q;
			end
			tilw_pkg::MODE_SWAP: begin
				outer_lim  = c_q;
				second_lim = n_q;
			end
			default: begin
				outer_lim  = DIM_W'(1);
				second_lim = DIM_W'(1);
			end
		endcase
	end

	assign mode       = mode_q;
	assign w_dim      = w_q;
	assign h_dim      = h_q;
	assign row_step   = (mode_q == tilw_pkg::MODE_FOLD) ? PIX_W'(wblk_cnt) : width_q;
	assign plane_step = plane_q;
	assign block_step = PIX_W'(w_q);

endmodule

@@ rtl/core/tilw_walk.sv @@
// Position counters, running pixel offsets and the input register stage.
// Depends on tilw_pkg.
module tilw_walk #(
	parameter int MAX_DIM   = tilw_pkg::DEF_MAX_DIM,
	parameter int ADDR_BITS = tilw_pkg::DEF_ADDR_BITS,
	localparam int DIM_W    = $clog2(MAX_DIM + 1),
	localparam int CNT_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int PIX_W    = ADDR_BITS - 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic                          busy,
	input  tilw_pkg::layout_mode_t        mode,
	input  logic [DIM_W-1:0]              w_dim,
	input  logic [DIM_W-1:0]              h_dim,
	input  logic [DIM_W-1:0]              outer_lim,
	input  logic [DIM_W-1:0]              second_lim,
	input  logic [PIX_W-1:0]              row_step,
	input  logic [PIX_W-1:0]              plane_step,
	input  logic [PIX_W-1:0]              block_step,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tilw_pkg::VALUE_W-1:0]  element_value,
	input  logic                          s1_take,
	output logic                          s1_valid,
	output logic [PIX_W-1:0]              s1_base,
	output logic [PIX_W-1:0]              s1_col,
	output tilw_pkg::item_ctl_t           s1_ctl,
	output logic [tilw_pkg::VALUE_W-1:0]  s1_value
);

	localparam int CMP_W = DIM_W + 1;

	logic [CNT_W-1:0]               col_q, row_q, sec_q, out_q;
	logic [CNT_W+1:0]               col_x, sec_x, out_x;
	logic [PIX_W-1:0]               base_q, off_outer_q, off_second_q;
	logic [PIX_W-1:0]               sec_step, out_step, off_second_nx, off_outer_nx;
	logic                           col_last, row_last, sec_last, out_last;
	logic                           accept;
	tilw_pkg::item_ctl_t            ctl;
	logic [PIX_W-1:0]               col_term;

	logic                           v_s1;
	logic [PIX_W-1:0]               base_s1, col_s1;
	tilw_pkg::item_ctl_t            ctl_s1;
	logic [tilw_pkg::VALUE_W-1:0]   value_s1;

	assign accept   = in_valid && in_ready;
	assign in_ready = !busy && (!v_s1 || s1_take);

	// End-of-range tests for each counter.
	assign col_last = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(w_dim);
	assign row_last = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(h_dim);
	assign sec_last = (CMP_W'(sec_q) + CMP_W'(1)) >= CMP_W'(second_lim);
	assign out_last = (CMP_W'(out_q) + CMP_W'(1)) >= CMP_W'(outer_lim);

	assign col_x = {2'b00, col_q};
	assign sec_x = {2'b00, sec_q};
	assign out_x = {2'b00, out_q};

	// Lane, padding and column term of the current element; strides per mode.
	always_comb begin
		ctl.done = col_last && row_last && sec_last && out_last;
		unique case (mode)
			tilw_pkg::MODE_CHAN, tilw_pkg::MODE_SWAP: begin
				ctl.lane = sec_x[1:0];
				ctl.pad  = sec_last;
				col_term = PIX_W'(col_q);
				sec_step = (sec_x[1:0] == tilw_pkg::LAST_LANE) ? block_step : '0;
				out_step = plane_step;
			end
			tilw_pkg::MODE_BATCH: begin
				ctl.lane = out_x[1:0];
				ctl.pad  = out_last;
				col_term = PIX_W'(col_q);
				sec_step = plane_step;
				out_step = (out_x[1:0] == tilw_pkg::LAST_LANE) ? block_step : '0;
			end
			default: begin
				ctl.lane = col_x[1:0];
				ctl.pad  = 1'b0;
				col_term = PIX_W'(col_x >> 2);
				sec_step = '0;
				out_step = '0;
			end
		endcase
	end

	assign off_second_nx = off_second_q + sec_step;
	assign off_outer_nx  = off_outer_q + out_step;

	// Counters advance innermost first; the row base follows each wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			sec_q        <= '0;
			out_q        <= '0;
			base_q       <= '0;
			off_outer_q  <= '0;
			off_second_q <= '0;
		end else if (restart) begin
			col_q        <= '0;
			row_q        <= '0;
			sec_q        <= '0;
			out_q        <= '0;
			base_q       <= '0;
			off_outer_q  <= '0;
			off_second_q <= '0;
		end else if (accept) begin
			if (!col_last) begin
				col_q <= col_q + CNT_W'(1);
			end else begin
				col_q <= '0;
				if (!row_last) begin
					row_q  <= row_q + CNT_W'(1);
					base_q <= base_q + row_step;
				end else begin
					row_q <= '0;
					if (!sec_last) begin
						sec_q        <= sec_q + CNT_W'(1);
						off_second_q <= off_second_nx;
						base_q       <= off_outer_q + off_second_nx;
					end else begin
						sec_q        <= '0;
						off_second_q <= '0;
						if (!out_last) begin
							out_q       <= out_q + CNT_W'(1);
							off_outer_q <= off_outer_nx;
							base_q      <= off_outer_nx;
						end else begin
							out_q       <= '0;
							off_outer_q <= '0;
							base_q      <= '0;
						end
					end
				end
			end
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_take) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_s1  <= base_q;
			col_s1   <= col_term;
			ctl_s1   <= ctl;
			value_s1 <= element_value;
		end
	end

	assign s1_valid = v_s1;
	assign s1_base  = base_s1;
	assign s1_col   = col_s1;
	assign s1_ctl   = ctl_s1;
	assign s1_value = value_s1;

endmodule

@@ rtl/core/tilw_emit.sv @@
// Result register: forms the image address and issues the padding lanes.
// Depends on tilw_pkg.
module tilw_emit #(
	parameter int ADDR_BITS = tilw_pkg::DEF_ADDR_BITS,
	localparam int PIX_W    = ADDR_BITS - 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s1_valid,
	input  logic [PIX_W-1:0]                 s1_base,
	input  logic [PIX_W-1:0]                 s1_col,
	input  tilw_pkg::item_ctl_t              s1_ctl,
	input  logic [tilw_pkg::VALUE_W-1:0]     s1_value,
	output logic                             s1_take,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tilw_pkg::ADDR_OUT_W-1:0]  write_address,
	output logic [tilw_pkg::VALUE_W-1:0]     write_value,
	output logic                             run_last,
	output logic                             tensor_done
);

	logic                            v_s2;
	logic [PIX_W-1:0]                pix_s2;
	logic [tilw_pkg::LANE_W-1:0]     lane_s2, last_lane_s2;
	logic [tilw_pkg::VALUE_W-1:0]    value_s2;
	logic                            done_s2;
	logic                            last_write;
	logic [ADDR_BITS-1:0]            addr_full;

	assign last_write = (lane_s2 == last_lane_s2);
	assign s1_take    = !v_s2 || (out_ready && last_write);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_take) begin
			v_s2 <= s1_valid;
		end
	end

	// Load a new item, or step to the next padding lane with a zero value.
	always_ff @(posedge clk) begin
		if (s1_take && s1_valid) begin
			pix_s2       <= s1_base + s1_col;
			lane_s2      <= s1_ctl.lane;
			last_lane_s2 <= s1_ctl.pad ? tilw_pkg::LAST_LANE : s1_ctl.lane;
			value_s2     <= s1_value;
			done_s2      <= s1_ctl.done;
		end else if (v_s2 && out_ready && !last_write) begin
			lane_s2  <= lane_s2 + tilw_pkg::LANE_W'(1);
			value_s2 <= '0;
		end
	end

	assign addr_full     = {pix_s2, lane_s2};
	assign out_valid     = v_s2;
	assign write_address = tilw_pkg::ADDR_OUT_W'(addr_full);
	assign write_value   = value_s2;
	assign run_last      = last_write;
	assign tensor_done   = done_s2 && last_write;

endmodule

@@ rtl/core/tensor_to_image_layout_writer.sv @@
// Tensor-to-image layout writer: one element item in, one to four image writes out.
// An accepted item passes the input register and then the result register before its first write.
// Throughput: one item per cycle while out_ready stays high; the item that closes a pixel
// in a blocked mode holds the result register until its padding lanes are written.
// Reset and every write to a listed register restart the position counters; items are
// held off afterwards while the row and plane strides settle.
module tensor_to_image_layout_writer #(
	parameter int MAX_DIM   = tilw_pkg::DEF_MAX_DIM,
	parameter int ADDR_BITS = tilw_pkg::DEF_ADDR_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tilw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tilw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tilw_pkg::VALUE_W-1:0]     element_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tilw_pkg::ADDR_OUT_W-1:0]  write_address,
	output logic [tilw_pkg::VALUE_W-1:0]     write_value,
	output logic                             run_last,
	output logic                             tensor_done
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int PIX_W = ADDR_BITS - 2;

	logic                           restart, busy;
	tilw_pkg::layout_mode_t         mode;
	logic [DIM_W-1:0]               w_dim, h_dim, outer_lim, second_lim;
	logic [PIX_W-1:0]               row_step, plane_step, block_step;
	logic                           s1_valid, s1_take;
	logic [PIX_W-1:0]               s1_base, s1_col;
	tilw_pkg::item_ctl_t            s1_ctl;
	logic [tilw_pkg::VALUE_W-1:0]   s1_value;

	// Registers and derived strides.
	tilw_cfg #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.restart    (restart),
		.busy       (busy),
		.mode       (mode),
		.w_dim      (w_dim),
		.h_dim      (h_dim),
		.outer_lim  (outer_lim),
		.second_lim (second_lim),
		.row_step   (row_step),
		.plane_step (plane_step),
		.block_step (block_step)
	);

	// Position tracking and input register.
	tilw_walk #(
		.MAX_DIM   (MAX_DIM),
		.ADDR_BITS (ADDR_BITS)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.busy          (busy),
		.mode          (mode),
		.w_dim         (w_dim),
		.h_dim         (h_dim),
		.outer_lim     (outer_lim),
		.second_lim    (second_lim),
		.row_step      (row_step),
		.plane_step    (plane_step),
		.block_step    (block_step),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element_value (element_value),
		.s1_take       (s1_take),
		.s1_valid      (s1_valid),
		.s1_base       (s1_base),
		.s1_col        (s1_col),
		.s1_ctl        (s1_ctl),
		.s1_value      (s1_value)
	);

	// Result register and padding lanes.
	tilw_emit #(
		.ADDR_BITS (ADDR_BITS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.s1_valid      (s1_valid),
		.s1_base       (s1_base),
		.s1_col        (s1_col),
		.s1_ctl        (s1_ctl),
		.s1_value      (s1_value),
		.s1_take       (s1_take),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_address (write_address),
		.write_value   (write_value),
		.run_last      (run_last),
		.tensor_done   (tensor_done)
	);

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the tensor-to-image layout writer: streams element items under
// random handshake gaps and compares every image write with a cycle-free predictor.
// Depends on tilw_pkg and tensor_to_image_layout_writer only.
`timescale 1ns / 1ps

module tb;

	localparam int NUM_REGS = 5;
	localparam logic [tilw_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
	localparam int RANDOM_ITEMS = 350;
	localparam int MAX_GAP = 13;
	localparam int DRAIN_CYCLES = 6;

	// Predictor of the image writes and store of the writes still awaited.
	class layout_scoreboard;
		typedef struct packed {
			logic [31:0] addr;
			logic [31:0] value;
			logic        last;
			logic        done;
		} image_write_t;

		tilw_pkg::layout_mode_t          mode;
		logic [tilw_pkg::SIZE_W-1:0]     dim_n, dim_c, dim_h, dim_w;
		longint unsigned                 pos_outer, pos_second, pos_row, pos_col;
		image_write_t                    awaited[$];
		int unsigned                     errors;

		function new();
			mode = tilw_pkg::MODE_CHAN;
			dim_n = 1;
			dim_c = 1;
			dim_h = 1;
			dim_w = 1;
			errors = 0;
			restart_walk();
		endfunction

		function void restart_walk();
			pos_outer = 0;
			pos_second = 0;
			pos_row = 0;
			pos_col = 0;
		endfunction

		// A size of zero counts as one; anything above the limit saturates.
		function longint unsigned clamp_dim(logic [tilw_pkg::SIZE_W-1:0] v);
			if (v == 0) return 1;
			if (v > tilw_pkg::DEF_MAX_DIM) return tilw_pkg::DEF_MAX_DIM;
			return v;
		endfunction

		// Writes to indexes past the register list change nothing, not even the walk.
		function void write_reg(logic [tilw_pkg::CFG_IDX_W-1:0] idx,
				logic [tilw_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tilw_pkg::REG_MODE:   mode = tilw_pkg::layout_mode_t'(data[1:0]);
				tilw_pkg::REG_SIZE_N: dim_n = data;
				tilw_pkg::REG_SIZE_C: dim_c = data;
				tilw_pkg::REG_SIZE_H: dim_h = data;
				tilw_pkg::REG_SIZE_W: dim_w = data;
				default:              return;
			endcase
			restart_walk();
		endfunction

		// Works out the writes caused by one accepted element and moves the walk on.
		function void note_element(logic [31:0] v);
			longint unsigned n_eff, c_eff, h_eff, w_eff, o, s, h, w;
			longint unsigned outer_lim, second_lim, bdim, width, pixel, lane;
			bit pad, done;
			int unsigned nwrites;
			image_write_t wr;
			n_eff = clamp_dim(dim_n);
			c_eff = clamp_dim(dim_c);
			h_eff = clamp_dim(dim_h);
			w_eff = clamp_dim(dim_w);
			o = pos_outer;
			s = pos_second;
			h = pos_row;
			w = pos_col;
			pad = 1'b0;
			case (mode)
				tilw_pkg::MODE_CHAN, tilw_pkg::MODE_SWAP: begin
					bdim = (mode == tilw_pkg::MODE_CHAN) ? c_eff : n_eff;
					outer_lim = (mode == tilw_pkg::MODE_CHAN) ? n_eff : c_eff;
					second_lim = bdim;
					width = w_eff * ((bdim + 3) / 4);
					pixel = (o * h_eff + h) * width + (s / 4) * w_eff + w;
					lane = s % 4;
					pad = (s == bdim - 1);
				end
				tilw_pkg::MODE_BATCH: begin
					outer_lim = n_eff;
					second_lim = c_eff;
					width = w_eff * ((n_eff + 3) / 4);
					pixel = (s * h_eff + h) * width + (o / 4) * w_eff + w;
					lane = o % 4;
					pad = (o == n_eff - 1);
				end
				default: begin
					outer_lim = 1;
					second_lim = 1;
					width = (w_eff + 3) / 4;
					pixel = h * width + w / 4;
					lane = w % 4;
				end
			endcase
			done = (w + 1 >= w_eff) && (h + 1 >= h_eff) && (s + 1 >= second_lim)
				&& (o + 1 >= outer_lim);

			// The real lane first, then zero for every lane above it when the pixel closes.
			nwrites = pad ? 4 - lane : 1;
			for (int unsigned i = 0; i < nwrites; i++) begin
				wr.addr = 32'(pixel * 4 + lane + i);
				wr.value = (i == 0) ? v : 32'd0;
				wr.last = (i == nwrites - 1);
				wr.done = wr.last && done;
				awaited.push_back(wr);
			end

			// Innermost counter first; the whole walk wraps after the final element.
			w++;
			if (w >= w_eff) begin
				w = 0;
				h++;
				if (h >= h_eff) begin
					h = 0;
					s++;
					if (s >= second_lim) begin
						s = 0;
						o++;
						if (o >= outer_lim) o = 0;
					end
				end
			end
			pos_outer = o;
			pos_second = s;
			pos_row = h;
			pos_col = w;
		endfunction

		function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
			errors++;
			$display("%0t: %s expected %h, actual %h", $time, field, exp_v, act_v);
		endfunction

		function void check_write(logic [31:0] addr, logic [31:0] value, logic last,
				logic done);
			image_write_t exp_wr;
			if (awaited.size() == 0) begin
				report("write with nothing awaited, address", 32'hx, addr);
				return;
			end
			exp_wr = awaited.pop_front();
			if (addr !== exp_wr.addr) report("write_address", exp_wr.addr, addr);
			if (value !== exp_wr.value) report("write_value", exp_wr.value, value);
			if (last !== exp_wr.last) report("run_last", 32'(exp_wr.last), 32'(last));
			if (done !== exp_wr.done) report("tensor_done", 32'(exp_wr.done), 32'(done));
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write;
	logic [tilw_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [tilw_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic [tilw_pkg::VALUE_W-1:0]     element_value;
	logic                             out_valid;
	logic                             out_ready;
	logic [tilw_pkg::ADDR_OUT_W-1:0]  write_address;
	logic [tilw_pkg::VALUE_W-1:0]     write_value;
	logic                             run_last;
	logic                             tensor_done;

	layout_scoreboard sb;
	bit tx_burst;
	bit rx_burst;

	// Register values the stimulus believes are loaded.
	tilw_pkg::layout_mode_t        cur_mode;
	logic [tilw_pkg::SIZE_W-1:0]   cur_n, cur_c, cur_h, cur_w;

	tensor_to_image_layout_writer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_address (write_address),
		.write_value   (write_value),
		.run_last      (run_last),
		.tensor_done   (tensor_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Observe register writes, accepted items and accepted writes at each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_element(element_value);
			if (out_valid && out_ready)
				sb.check_write(write_address, write_value, run_last, tensor_done);
		end
	end

	// Receiver: a fresh random stall before each write, none in burst stretches.
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic cfg_write_reg(input logic [tilw_pkg::CFG_IDX_W-1:0] idx,
			input logic [tilw_pkg::CFG_DATA_W-1:0] data);
		if (!cfg_write) cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Loads the selected registers from cur_*, optionally followed by a stray index.
	task automatic program_regs(input bit [NUM_REGS-1:0] sel, input bit stray);
		logic [tilw_pkg::CFG_DATA_W-1:0] vals [NUM_REGS];
		vals[tilw_pkg::REG_MODE] = (13'($urandom) & ~13'd3) | 13'(cur_mode);
		vals[tilw_pkg::REG_SIZE_N] = cur_n;
		vals[tilw_pkg::REG_SIZE_C] = cur_c;
		vals[tilw_pkg::REG_SIZE_H] = cur_h;
		vals[tilw_pkg::REG_SIZE_W] = cur_w;
		for (int i = 0; i < NUM_REGS; i++)
			if (sel[i]) cfg_write_reg(tilw_pkg::CFG_IDX_W'(i), vals[i]);
		if (stray)
			cfg_write_reg(tilw_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST,
				(1 << tilw_pkg::CFG_IDX_W) - 1)), 13'($urandom));
		if (sel != 0 || stray) cfg_write <= 1'b0;
	endtask

	task automatic send_item(input logic [tilw_pkg::VALUE_W-1:0] v);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Waits until every awaited write has come, then lets the pipeline settle.
	task automatic wait_drain();
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic stream_values(input logic [tilw_pkg::VALUE_W-1:0] vals[$],
			input bit pause_mid);
		for (int i = 0; i < vals.size(); i++) begin
			send_item(vals[i]);
			if (pause_mid && i == vals.size() / 2) begin
				in_valid <= 1'b0;
				wait_drain();
			end
		end
		in_valid <= 1'b0;
		wait_drain();
	endtask

	function automatic logic [tilw_pkg::SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return 13'd8191;
			2:       return 13'(tilw_pkg::DEF_MAX_DIM);
			3:       return 13'($urandom_range(tilw_pkg::DEF_MAX_DIM + 1, 8191));
			4:       return 13'($urandom_range(1, tilw_pkg::DEF_MAX_DIM));
			default: return 13'($urandom_range(1, 6));
		endcase
	endfunction

	// Main sequence: reset, a directed part, then random tensors.
	initial begin
		logic [tilw_pkg::VALUE_W-1:0] vals[$];
		int random_done;
		int count;
		longint unsigned elems;
		bit [NUM_REGS-1:0] sel;
		sb = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		element_value = '0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		cur_mode = tilw_pkg::MODE_CHAN;
		cur_n = 1;
		cur_c = 1;
		cur_h = 1;
		cur_w = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: one-element tensor, three padding lanes and done on every item.
		stream_values('{32'h0000_0000, 32'hFFFF_FFFF}, 1'b0);

		// Folded rows; N of zero and an oversized C are ignored here. Runs past the end.
		cur_mode = tilw_pkg::MODE_FOLD;
		cur_n = 0;
		cur_c = 13'd8191;
		cur_h = 2;
		cur_w = 3;
		program_regs('1, 1'b0);
		stream_values('{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF,
			32'h8000_0001, 32'h7FFF_FFFE, 32'h1234_5678}, 1'b0);

		// Batch blocks with a stray register index written mid-tensor.
		cur_mode = tilw_pkg::MODE_BATCH;
		cur_n = 3;
		cur_c = 2;
		cur_h = 1;
		cur_w = 1;
		program_regs('1, 1'b0);
		stream_values('{32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0001}, 1'b0);
		program_regs('0, 1'b1);
		stream_values('{32'h8000_0000, 32'hCAFE_F00D, 32'h0BAD_BEEF}, 1'b1);

		// Swapped channel blocks.
		cur_mode = tilw_pkg::MODE_SWAP;
		cur_n = 2;
		cur_c = 2;
		program_regs('1, 1'b0);
		stream_values('{32'h3C3C_3C3C, 32'hC3C3_C3C3, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0);

		// Channel count above the limit saturates the row width.
		cur_mode = tilw_pkg::MODE_CHAN;
		cur_n = 1;
		cur_c = 13'd8191;
		cur_h = 2;
		cur_w = 1;
		program_regs('1, 1'b0);
		stream_values('{32'h1111_1111, 32'h2222_2222, 32'h3333_3333}, 1'b0);

		// Random tensors, mostly small and often run past the end to see the wrap.
		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			tx_burst = ($urandom_range(0, 4) == 0);
			rx_burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 7) != 0) begin
				sel = ($urandom_range(0, 3) == 0) ? NUM_REGS'($urandom_range(1, 31)) : '1;
				if (sel[tilw_pkg::REG_MODE])
					cur_mode = tilw_pkg::layout_mode_t'($urandom_range(0, 3));
				if (sel[tilw_pkg::REG_SIZE_N]) cur_n = pick_size();
				if (sel[tilw_pkg::REG_SIZE_C]) cur_c = pick_size();
				if (sel[tilw_pkg::REG_SIZE_H]) cur_h = pick_size();
				if (sel[tilw_pkg::REG_SIZE_W]) cur_w = pick_size();
				program_regs(sel, $urandom_range(0, 7) == 0);
				elems = sb.clamp_dim(cur_h) * sb.clamp_dim(cur_w);
				if (cur_mode != tilw_pkg::MODE_FOLD)
					elems = elems * sb.clamp_dim(cur_n) * sb.clamp_dim(cur_c);
				count = (elems <= 40) ? int'(elems) + $urandom_range(0, int'(elems))
					: $urandom_range(5, 40);
			end else begin
				count = $urandom_range(5, 30);
			end
			vals.delete();
			repeat (count) vals.push_back($urandom);
			stream_values(vals, $urandom_range(0, 9) == 0);
			random_done += count;
		end

		tx_burst = 1'b0;
		rx_burst = 1'b0;
		wait_drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
